>>> hdl/bmpu_pkg.sv
package bmpu_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int DIM_W       = 13;
   localparam int COORD_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int BIT_IDX_W   = $clog2(BYTE_W);
   localparam int PAD_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X     = 3'd0,
      REG_ORIGIN_Y     = 3'd1,
      REG_IMAGE_WIDTH  = 3'd2,
      REG_IMAGE_HEIGHT = 3'd3,
      REG_TOP_DOWN     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   // one image byte with its screen position, handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] x_base;
      logic [COORD_W-1:0] y;
      logic [BYTE_W-1:0]  data;
   } pix_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
   endfunction

endpackage

>>> hdl/bmpu_if.sv
interface bmpu_req_if;
   import bmpu_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bmpu_rsp_if;
   import bmpu_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic               pixel_white;
   logic               last_of_byte;

   modport source (output valid, output pixel_x, output pixel_y, output pixel_white,
                   output last_of_byte, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input pixel_white,
                   input last_of_byte, output ready);
endinterface

>>> hdl/bmpu_front.sv
module bmpu_front
   import bmpu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  csr_write_type     csr,
   input  logic              req_fire,
   input  logic [BYTE_W-1:0] req_data,
   output logic              push,
   output pix_item_type      push_item
);

   logic [COORD_W-1:0] origin_x_ff, origin_x_in;
   logic [COORD_W-1:0] origin_y_ff, origin_y_in;
   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic               top_down_ff, top_down_in;

   logic [DIM_W-1:0]   column_ff, column_in;
   logic [DIM_W-1:0]   row_ff, row_in;
   logic [DIM_W-1:0]   rows_done_ff, rows_done_in;
   logic [PAD_W-1:0]   pad_ff, pad_in;

   logic [DIM_W-1:0]   w_eff;
   logic [DIM_W-1:0]   h_eff;
   logic [DIM_W:0]     next_col;
   logic [DIM_W:0]     width_round;
   logic               restart;
   logic               frame_done;

   assign w_eff       = clamp_dim(width_ff);
   assign h_eff       = clamp_dim(height_ff);
   assign frame_done  = (rows_done_ff >= h_eff);
   assign next_col    = {1'b0, column_ff} + (DIM_W+1)'(BYTE_W);
   assign width_round = {1'b0, w_eff} + (DIM_W+1)'(BYTE_W - 1);

   assign push             = req_fire && !frame_done && (pad_ff == '0);
   assign push_item.x_base = origin_x_ff + {{(COORD_W-DIM_W){1'b0}}, column_ff};
   assign push_item.y      = origin_y_ff + {{(COORD_W-DIM_W){1'b0}}, row_ff};
   assign push_item.data   = req_data;

   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      top_down_in  = top_down_ff;
      restart      = 1'b0;
      column_in    = column_ff;
      row_in       = row_ff;
      rows_done_in = rows_done_ff;
      pad_in       = pad_ff;

      if (csr.we) begin
         unique case (csr.index)
            REG_ORIGIN_X:     origin_x_in = csr.data[COORD_W-1:0];
            REG_ORIGIN_Y:     origin_y_in = csr.data[COORD_W-1:0];
            REG_IMAGE_WIDTH: begin
               width_in = csr.data[DIM_W-1:0];
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr.data[DIM_W-1:0];
               restart   = 1'b1;
            end
            REG_TOP_DOWN: begin
               top_down_in = csr.data[0];
               restart     = 1'b1;
            end
            default: ;
         endcase
      end

      if (restart) begin
         column_in    = '0;
         rows_done_in = '0;
         pad_in       = '0;
         row_in       = top_down_in ? '0 : clamp_dim(height_in) - DIM_W'(1);
      end else if (req_fire && !frame_done) begin
         if (pad_ff != '0) begin
            pad_in = pad_ff - PAD_W'(1);
         end else if (next_col >= {1'b0, w_eff}) begin
            column_in    = '0;
            row_in       = top_down_ff ? row_ff + DIM_W'(1) : row_ff - DIM_W'(1);
            rows_done_in = rows_done_ff + DIM_W'(1);
            // bytes per row mod 4, negated, is the padding to the next word
            pad_in       = PAD_W'(0) - width_round[BIT_IDX_W +: PAD_W];
         end else begin
            column_in = next_col[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         width_ff     <= DIM_W'(8);
         height_ff    <= DIM_W'(1);
         top_down_ff  <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         rows_done_ff <= '0;
         pad_ff       <= '0;
      end else begin
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         top_down_ff  <= top_down_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         rows_done_ff <= rows_done_in;
         pad_ff       <= pad_in;
      end
   end

endmodule

>>> hdl/bmpu_queue.sv
module bmpu_queue
   import bmpu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pix_item_type     push_item,
   input  logic             pop,
   output pix_item_type     head,
   output queue_status_type status
);

   pix_item_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/bmpu_back.sv
module bmpu_back
   import bmpu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  pix_item_type     head,
   input  queue_status_type q_status,
   output logic             pop,
   bmpu_rsp_if.source       rsp_ch
);

   logic                 busy_ff, busy_in;
   logic [BIT_IDX_W-1:0] bit_ff, bit_in;
   logic [COORD_W-1:0]   x_ff, x_in;
   logic [COORD_W-1:0]   y_ff, y_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic                 last_bit;
   logic                 rsp_fire;

   assign last_bit  = (bit_ff == BIT_IDX_W'(BYTE_W - 1));
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   // take the next byte when idle or as the eighth pixel leaves
   assign pop       = (!busy_ff || (rsp_fire && last_bit)) && !q_status.empty;

   assign rsp_ch.valid        = busy_ff;
   assign rsp_ch.pixel_x      = x_ff;
   assign rsp_ch.pixel_y      = y_ff;
   assign rsp_ch.pixel_white  = shift_ff[BYTE_W-1];
   assign rsp_ch.last_of_byte = last_bit;

   always_comb begin
      busy_in  = busy_ff;
      bit_in   = bit_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      shift_in = shift_ff;
      if (pop) begin
         busy_in  = 1'b1;
         bit_in   = '0;
         x_in     = head.x_base;
         y_in     = head.y;
         shift_in = head.data;
      end else if (rsp_fire) begin
         if (last_bit) begin
            busy_in = 1'b0;
         end
         bit_in   = bit_ff + BIT_IDX_W'(1);
         x_in     = x_ff + COORD_W'(1);
         shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         bit_ff  <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      shift_ff <= shift_in;
   end

endmodule

>>> hdl/bmp_mono_pixel_unpacker.sv
// 1-bit bitmap pixel-data unpacker. Each image byte accepted on req_ch gives
// eight pixel writes on rsp_ch, most significant bit first, at consecutive
// screen x from origin_x plus the current column and at y = origin_y plus the
// current row; a set bit paints white and the eighth write is flagged
// last_of_byte. The serializer in the back end emits one pixel per cycle while
// rsp_ch.ready is high; row padding bytes and bytes after the last row produce
// nothing and are taken whenever the two-entry queue has room. Rows run upward
// unless top_down is set. Writing image_width, image_height or top_down restarts
// the frame; the user is to write registers only while the block is idle; the
// block itself does not enforce it.
module bmp_mono_pixel_unpacker
   import bmpu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bmpu_req_if.sink              req_ch,
   bmpu_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   csr_write_type    csr;
   pix_item_type     push_item;
   pix_item_type     head;
   queue_status_type q_status;
   logic             push;
   logic             pop;
   logic             req_fire;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   assign req_ch.ready = !q_status.full;
   assign req_fire     = req_ch.valid && req_ch.ready;

   bmpu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .req_fire  (req_fire),
      .req_data  (req_ch.data_byte),
      .push      (push),
      .push_item (push_item)
   );

   bmpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   bmpu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("push into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty))
      else $error("pop from an empty queue");

   a_x_steps_within_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_of_byte) |=>
      (rsp_ch.valid && rsp_ch.pixel_x == COORD_W'($past(rsp_ch.pixel_x) + 1'b1)
       && rsp_ch.pixel_y == $past(rsp_ch.pixel_y)))
      else $error("pixel position did not advance by one within a byte");

endmodule
